// File: rtl/acr_pkg.sv
package acr_pkg;

  // Default widths for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int STORE_WIDTH_DEF  = 24;
  localparam int GAIN_WIDTH_DEF   = 16;

  // Fixed-point format of values in flight
  localparam int FRAC_BITS = 16;

  // Result field
  localparam int OUT_WIDTH   = 24;
  localparam int OUT_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

  // Delay line layout in the shared memory
  localparam int NUM_LINES   = 7;
  localparam int NUM_AP      = 3;
  localparam int NUM_COMBS   = 4;
  localparam int TOTAL_DEPTH = 389 + 127 + 43 + 1777 + 1847 + 1993 + 2137;
  localparam int ADDR_W      = $clog2(TOTAL_DEPTH);
  localparam int POS_W       = $clog2(2137);
  localparam int LINE_W      = $clog2(NUM_LINES);
  localparam int COMB_IDX_W  = $clog2(NUM_COMBS);

  typedef logic [LINE_W-1:0] line_idx_t;

  localparam line_idx_t LINE_AP_A = 3'd0;
  localparam line_idx_t LINE_AP_B = 3'd1;
  localparam line_idx_t LINE_AP_C = 3'd2;
  localparam line_idx_t LINE_CB_A = 3'd3;
  localparam line_idx_t LINE_CB_B = 3'd4;
  localparam line_idx_t LINE_CB_C = 3'd5;
  localparam line_idx_t LINE_CB_D = 3'd6;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN_3 = 3'd4;

  // Reset gains as Q0.16 values
  localparam int  GAIN_REF_BITS  = 16;
  localparam longint AP_GAIN_Q16 = 45875;
  localparam longint CB_GAIN_Q16_0 = 49617;
  localparam longint CB_GAIN_Q16_1 = 49075;
  localparam longint CB_GAIN_Q16_2 = 47966;
  localparam longint CB_GAIN_Q16_3 = 46898;

  // Rescale a Q0.16 gain to Q0.gw
  function automatic longint scale_gain(input longint q16, input int gw);
    return (q16 << gw) >> GAIN_REF_BITS;
  endfunction

  // First memory address of each line
  function automatic logic [ADDR_W-1:0] line_base(input line_idx_t k);
    logic [ADDR_W-1:0] b;
    case (k)
      LINE_AP_A: b = ADDR_W'(0);
      LINE_AP_B: b = ADDR_W'(389);
      LINE_AP_C: b = ADDR_W'(389 + 127);
      LINE_CB_A: b = ADDR_W'(389 + 127 + 43);
      LINE_CB_B: b = ADDR_W'(389 + 127 + 43 + 1777);
      LINE_CB_C: b = ADDR_W'(389 + 127 + 43 + 1777 + 1847);
      LINE_CB_D: b = ADDR_W'(389 + 127 + 43 + 1777 + 1847 + 1993);
      default:   b = ADDR_W'(0);
    endcase
    return b;
  endfunction

  // Last position of each line
  function automatic logic [POS_W-1:0] line_last(input line_idx_t k);
    logic [POS_W-1:0] p;
    case (k)
      LINE_AP_A: p = POS_W'(389 - 1);
      LINE_AP_B: p = POS_W'(127 - 1);
      LINE_AP_C: p = POS_W'(43 - 1);
      LINE_CB_A: p = POS_W'(1777 - 1);
      LINE_CB_B: p = POS_W'(1847 - 1);
      LINE_CB_C: p = POS_W'(1993 - 1);
      LINE_CB_D: p = POS_W'(2137 - 1);
      default:   p = POS_W'(0);
    endcase
    return p;
  endfunction

  // Request from the sequencer to the delay store
  typedef struct packed {
    logic      rd_en;
    line_idx_t rd_line;
    logic      wr_en;
    line_idx_t wr_line;
  } store_ctl_t;

endpackage

// File: rtl/acr_delay_store.sv
module acr_delay_store #(
  parameter int STORE_WIDTH = acr_pkg::STORE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  acr_pkg::store_ctl_t     ctl,
  input  logic [STORE_WIDTH-1:0]  wr_data,
  output logic [STORE_WIDTH-1:0]  rd_data
);
  import acr_pkg::*;

  logic [STORE_WIDTH-1:0] mem [TOTAL_DEPTH];
  logic [POS_W-1:0]       pos_r [NUM_LINES];
  logic [NUM_LINES-1:0]   full_r;
  logic [STORE_WIDTH-1:0] mem_q_r;
  logic                   rd_full_r;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      rd_addr_r;

  // Address of the current position of the requested line
  assign rd_addr = line_base(ctl.rd_line) + ADDR_W'(pos_r[ctl.rd_line]);

  // Write back to the entry read last; no other read comes between
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[rd_addr_r] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q_r   <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // An entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_full_r <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_full_r <= full_r[ctl.rd_line];
    end
  end

  assign rd_data = rd_full_r ? mem_q_r : '0;

  // Advance the written line's position; mark it full on its first wrap
  for (genvar k = 0; k < NUM_LINES; k++) begin : g_pos
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r[k]  <= '0;
        full_r[k] <= 1'b0;
      end else if (ctl.wr_en && ctl.wr_line == line_idx_t'(k)) begin
        if (pos_r[k] == line_last(line_idx_t'(k))) begin
          pos_r[k]  <= '0;
          full_r[k] <= 1'b1;
        end else begin
          pos_r[k] <= pos_r[k] + POS_W'(1);
        end
      end
    end
  end

endmodule

// File: rtl/allpass_comb_reverberator_unit.sv
// One request at a time: in_tready is high only in S_IDLE, after the last result is loaded for output.
// Each item makes seven read-modify-writes of the shared delay memory, one line after
// another, with one multiplier shared by all gain products: each allpass section steps
// through S_AP_M1, S_AP_W, S_AP_M2 and S_AP_X, each comb through S_CB_M and S_CB_S.
// Reset (rst_n low, synchronous): gains return to defaults, all delay lines read as
// zero until first written, output holds no result; no clearing pass is needed.
module allpass_comb_reverberator_unit #(
  parameter int SAMPLE_WIDTH = acr_pkg::SAMPLE_WIDTH_DEF,
  parameter int STORE_WIDTH  = acr_pkg::STORE_WIDTH_DEF,
  parameter int GAIN_WIDTH   = acr_pkg::GAIN_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // left_sample, right_sample (from bit 0 up), zero padded to bytes
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // reverb_sample (from bit 0 up)
  output logic [acr_pkg::OUT_TDATA_W-1:0]             out_tdata,
  input  logic                                        cfg_wr_en,
  input  logic [acr_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [GAIN_WIDTH-1:0]                       cfg_wdata
);
  import acr_pkg::*;

  localparam int MAXW = (SAMPLE_WIDTH > STORE_WIDTH) ? SAMPLE_WIDTH : STORE_WIDTH;
  localparam int IW   = MAXW + FRAC_BITS + 6;
  localparam int AW   = IW + 2;

  localparam logic signed [IW-1:0] ST_MAX =
    {{(IW-STORE_WIDTH+1){1'b0}}, {(STORE_WIDTH-1){1'b1}}};
  localparam logic signed [IW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [AW-1:0] OUT_MAX =
    {{(AW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] OUT_MIN = ~OUT_MAX;

  localparam logic [GAIN_WIDTH-1:0] AP_GAIN_RST  = GAIN_WIDTH'(scale_gain(AP_GAIN_Q16, GAIN_WIDTH));
  localparam logic [GAIN_WIDTH-1:0] CB_GAIN_RST0 = GAIN_WIDTH'(scale_gain(CB_GAIN_Q16_0, GAIN_WIDTH));
  localparam logic [GAIN_WIDTH-1:0] CB_GAIN_RST1 = GAIN_WIDTH'(scale_gain(CB_GAIN_Q16_1, GAIN_WIDTH));
  localparam logic [GAIN_WIDTH-1:0] CB_GAIN_RST2 = GAIN_WIDTH'(scale_gain(CB_GAIN_Q16_2, GAIN_WIDTH));
  localparam logic [GAIN_WIDTH-1:0] CB_GAIN_RST3 = GAIN_WIDTH'(scale_gain(CB_GAIN_Q16_3, GAIN_WIDTH));

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_AP_M1 = 3'd1;
  localparam logic [2:0] S_AP_W  = 3'd2;
  localparam logic [2:0] S_AP_M2 = 3'd3;
  localparam logic [2:0] S_AP_X  = 3'd4;
  localparam logic [2:0] S_CB_M  = 3'd5;
  localparam logic [2:0] S_CB_S  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // floor(a * g / 2^GAIN_WIDTH)
  function automatic logic signed [IW-1:0] mul_gain(input logic signed [IW-1:0] a,
                                                    input logic [GAIN_WIDTH-1:0] g);
    logic signed [IW+GAIN_WIDTH:0] p;
    p = a * $signed({1'b0, g});
    return IW'(p >>> GAIN_WIDTH);
  endfunction

  // Q16 to stored integer: truncate toward zero, saturate
  function automatic logic [STORE_WIDTH-1:0] to_store(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] q;
    q = v >>> FRAC_BITS;
    if (v[IW-1] && |v[FRAC_BITS-1:0]) q = q + IW'(1);
    if (q > ST_MAX) q = ST_MAX;
    else if (q < ST_MIN) q = ST_MIN;
    return q[STORE_WIDTH-1:0];
  endfunction

  // Q16 sum to result sample: truncate toward zero, saturate
  function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] q;
    q = v >>> FRAC_BITS;
    if (v[AW-1] && |v[FRAC_BITS-1:0]) q = q + AW'(1);
    if (q > OUT_MAX) q = OUT_MAX;
    else if (q < OUT_MIN) q = OUT_MIN;
    return q[OUT_WIDTH-1:0];
  endfunction

  logic [2:0]             state_r, state_nxt;
  line_idx_t              line_r;
  logic [GAIN_WIDTH-1:0]  ap_gain_r;
  logic [GAIN_WIDTH-1:0]  comb_gain_r [NUM_COMBS];
  logic signed [IW-1:0]   x_r, w_r, prod_r;
  logic signed [IW-1:0]   prod_nxt;
  logic [STORE_WIDTH-1:0] t_r;
  logic signed [AW-1:0]   acc_r;
  logic                   out_valid_r;
  logic [OUT_WIDTH-1:0]   out_sample_r;

  store_ctl_t             st_ctl;
  logic [STORE_WIDTH-1:0] st_rd_data;
  logic [STORE_WIDTH-1:0] st_wr_data;

  logic                   in_acc;
  logic                   last_line;
  logic                   out_load;
  logic signed [SAMPLE_WIDTH-1:0] left_s, right_s;
  logic signed [SAMPLE_WIDTH:0]   in_sum;
  logic signed [IW-1:0]   in_x;
  logic signed [IW-1:0]   rd_ext, t_ext, sum_val, mul_a;
  logic [GAIN_WIDTH-1:0]  gain_sel;
  logic [COMB_IDX_W-1:0]  comb_idx;
  line_idx_t              comb_off;

  // Input request
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign left_s    = in_tdata[SAMPLE_WIDTH-1:0];
  assign right_s   = in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign in_sum    = (SAMPLE_WIDTH+1)'(left_s) + (SAMPLE_WIDTH+1)'(right_s);
  assign in_x      = IW'(in_sum) <<< FRAC_BITS;

  // Operand selection
  assign rd_ext    = IW'($signed(st_rd_data)) <<< FRAC_BITS;
  assign t_ext     = IW'($signed(t_r)) <<< FRAC_BITS;
  assign sum_val   = x_r + prod_r;
  assign mul_a     = (state_r == S_AP_M2) ? w_r : rd_ext;
  assign comb_off  = line_r - line_idx_t'(NUM_AP);
  assign comb_idx  = comb_off[COMB_IDX_W-1:0];
  assign gain_sel  = (line_r < line_idx_t'(NUM_AP)) ? ap_gain_r : comb_gain_r[comb_idx];
  assign last_line = (line_r == LINE_CB_D);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Shared gain multiplier
  assign prod_nxt  = mul_gain(mul_a, gain_sel);

  // Delay store requests
  always_comb begin
    st_ctl.rd_en   = in_acc || (state_r == S_AP_X) || (state_r == S_CB_S && !last_line);
    st_ctl.rd_line = (state_r == S_IDLE) ? LINE_AP_A : line_r + line_idx_t'(1);
    st_ctl.wr_en   = (state_r == S_AP_W) || (state_r == S_CB_S);
    st_ctl.wr_line = line_r;
  end

  assign st_wr_data = to_store(sum_val);

  acr_delay_store #(
    .STORE_WIDTH (STORE_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .wr_data (st_wr_data),
    .rd_data (st_rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_AP_M1;
      S_AP_M1: state_nxt = S_AP_W;
      S_AP_W:  state_nxt = S_AP_M2;
      S_AP_M2: state_nxt = S_AP_X;
      S_AP_X:  state_nxt = (line_r == LINE_AP_C) ? S_CB_M : S_AP_M1;
      S_CB_M:  state_nxt = S_CB_S;
      S_CB_S:  state_nxt = last_line ? S_DONE : S_CB_M;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      line_r      <= LINE_AP_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        line_r <= LINE_AP_A;
      end else if (state_r == S_AP_X || (state_r == S_CB_S && !last_line)) begin
        line_r <= line_r + line_idx_t'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_gain_r      <= AP_GAIN_RST;
      comb_gain_r[0] <= CB_GAIN_RST0;
      comb_gain_r[1] <= CB_GAIN_RST1;
      comb_gain_r[2] <= CB_GAIN_RST2;
      comb_gain_r[3] <= CB_GAIN_RST3;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AP_GAIN:     ap_gain_r      <= cfg_wdata;
        REG_COMB_GAIN_0: comb_gain_r[0] <= cfg_wdata;
        REG_COMB_GAIN_1: comb_gain_r[1] <= cfg_wdata;
        REG_COMB_GAIN_2: comb_gain_r[2] <= cfg_wdata;
        REG_COMB_GAIN_3: comb_gain_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Datapath: allpass w = g*t + x, x' = t - g*w; comb s = y + h*c
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= in_x;
      acc_r <= '0;
    end
    case (state_r)
      S_AP_M1: begin
        t_r    <= st_rd_data;
        prod_r <= prod_nxt;
      end
      S_AP_W:  w_r    <= sum_val;
      S_AP_M2: prod_r <= prod_nxt;
      S_AP_X:  x_r    <= t_ext - prod_r;
      S_CB_M:  prod_r <= prod_nxt;
      S_CB_S:  acc_r  <= acc_r + AW'(sum_val);
      default: ;
    endcase
    if (out_load) begin
      out_sample_r <= to_out(acc_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_sample_r);

endmodule

// File: rtl/acr_checker.sv
module acr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [acr_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // Hold the result while the consumer stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // Take no new request in the cycle after one is accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in progress");

  // A result never appears right after a request is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind allpass_comb_reverberator_unit acr_checker u_acr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import acr_pkg::*;

  localparam int SAMPLE_W  = SAMPLE_WIDTH_DEF;
  localparam int GAIN_W    = GAIN_WIDTH_DEF;
  localparam int STORE_W   = STORE_WIDTH_DEF;
  localparam int IN_DATA_W = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int MAX_DEPTH = 2137;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 163;
  localparam int NUM_PHASES   = 6;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [OUT_WIDTH-1:0] reverb_t;

  // Scoreboard: tracks the delay network and queues the expected mono output
  class reverb_scoreboard;
    int      mismatches;
    reverb_t pending_reverb[$];
    longint  line_mem[NUM_LINES][MAX_DEPTH];
    int      line_pos[NUM_LINES];
    int      line_depth[NUM_LINES];
    longint  ap_gain;
    longint  cb_gain[NUM_COMBS];

    function new();
      line_depth = '{389, 127, 43, 1777, 1847, 1993, 2137};
      foreach (line_pos[k]) line_pos[k] = 0;
      foreach (line_mem[k, i]) line_mem[k][i] = 0;
      ap_gain    = AP_GAIN_Q16;
      cb_gain[0] = CB_GAIN_Q16_0;
      cb_gain[1] = CB_GAIN_Q16_1;
      cb_gain[2] = CB_GAIN_Q16_2;
      cb_gain[3] = CB_GAIN_Q16_3;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    function int pending();
      return pending_reverb.size();
    endfunction

    // Apply a register write; indexes past the last gain are dropped
    function void configure(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
      case (idx)
        REG_AP_GAIN:     ap_gain    = value;
        REG_COMB_GAIN_0: cb_gain[0] = value;
        REG_COMB_GAIN_1: cb_gain[1] = value;
        REG_COMB_GAIN_2: cb_gain[2] = value;
        REG_COMB_GAIN_3: cb_gain[3] = value;
        default: ;
      endcase
    endfunction

    // Gain product, rounded toward minus infinity
    function longint gain_mul(longint a, longint g);
      return (a * g) >>> FRAC_BITS;
    endfunction

    function longint saturate(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // Read the tap of a line as a Q16 value
    function longint tap(int k);
      return line_mem[k][line_pos[k]] <<< FRAC_BITS;
    endfunction

    // Store truncated toward zero and saturated, then advance the position
    function void store_line(int k, longint q16);
      line_mem[k][line_pos[k]] = saturate(q16 / (longint'(1) <<< FRAC_BITS), STORE_W);
      line_pos[k] = (line_pos[k] + 1 == line_depth[k]) ? 0 : line_pos[k] + 1;
    endfunction

    function reverb_t predict_reverb(sample_t left, sample_t right);
      longint x, t, w, c, s, acc;
      x = (longint'(left) + longint'(right)) <<< FRAC_BITS;
      // Three allpass sections in series
      for (int k = 0; k < NUM_AP; k++) begin
        t = tap(k);
        w = gain_mul(t, ap_gain) + x;
        store_line(k, w);
        x = t - gain_mul(w, ap_gain);
      end
      // Four parallel feedback combs, summed
      acc = 0;
      for (int k = 0; k < NUM_COMBS; k++) begin
        c = tap(NUM_AP + k);
        s = x + gain_mul(c, cb_gain[k]);
        store_line(NUM_AP + k, s);
        acc += s;
      end
      acc = saturate(acc / (longint'(1) <<< FRAC_BITS), OUT_WIDTH);
      return reverb_t'(acc);
    endfunction

    function void note_request(sample_t left, sample_t right);
      pending_reverb.push_back(predict_reverb(left, right));
    endfunction

    task check_result(reverb_t got);
      reverb_t want;
      if (pending_reverb.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_reverb.pop_front();
        if (got !== want)
          report_mismatch($sformatf("reverb_sample got %h want %h", got, want));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [GAIN_W-1:0]      cfg_wdata = '0;
  logic                   no_idle = 1'b0;
  reverb_scoreboard       sb;

  allpass_comb_reverberator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // Mostly full-scale random, with extremes and near-zero values mixed in
  function automatic sample_t draw_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 4))
        0: return sample_t'(32767);
        1: return sample_t'(-32768);
        2: return sample_t'(0);
        3: return sample_t'(-1);
        default: return sample_t'(1);
      endcase
    end
    if (pick < 30) return sample_t'(int'($urandom_range(0, 255)) - 128);
    return sample_t'($urandom);
  endfunction

  // Offer one sample pair and hold it until the request is taken
  task automatic send_pair(sample_t left, sample_t right);
    int gap;
    gap = idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({right, left});
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(left, right);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.configure(idx, value);
  endtask

  task automatic write_gains(logic [GAIN_W-1:0] ap, logic [GAIN_W-1:0] c0,
                             logic [GAIN_W-1:0] c1, logic [GAIN_W-1:0] c2,
                             logic [GAIN_W-1:0] c3);
    write_reg(REG_AP_GAIN, ap);
    write_reg(REG_COMB_GAIN_0, c0);
    write_reg(REG_COMB_GAIN_1, c1);
    write_reg(REG_COMB_GAIN_2, c2);
    write_reg(REG_COMB_GAIN_3, c3);
  endtask

  // Drop valid and wait until every expected result is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Result side: stall at random, check each accepted result
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_cycles();
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_tdata[OUT_WIDTH-1:0]);
    end
  end

  // Watchdog: end the run after a long stretch with no handshake at all
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
          (out_tvalid === 1'b1 && out_tready === 1'b1) || cfg_wr_en === 1'b1 ||
          rst_n !== 1'b1)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    sample_t directed_l[$];
    sample_t directed_r[$];
    sb = new();

    // Hold reset, then release it on a falling clock edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, sum limits, sign boundaries
    directed_l = '{32767, -32768, 32767, -32768, 0, -1, 1, 0, -1, 32767,
                   -32768, 16384, -16384, 0, 32767, 32767, -32768, 255, -256, 0};
    directed_r = '{32767, -32768, -32768, 32767, 0, -1, 0, 1, 0, 0,
                   0, 16384, -16384, 32767, 32767, 32767, -32768, -255, 256, 0};
    no_idle = 1'b1;
    foreach (directed_l[i]) send_pair(directed_l[i], directed_r[i]);
    no_idle = 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      // Step through gain settings: defaults, then extremes, then random
      case (phase)
        0: ;
        1: begin
          write_gains('0, '0, '0, '0, '0);
          // Writes past the last register must be ignored
          for (int idx = REG_COMB_GAIN_3 + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), GAIN_W'($urandom));
        end
        2: write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        3: write_gains('0, GAIN_MAX, '0, GAIN_MAX, '0);
        4: write_gains(GAIN_MAX, '0, GAIN_MAX, '0, GAIN_MAX);
        default: write_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                             GAIN_W'($urandom), GAIN_W'($urandom));
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        // Switch between idling and back-to-back stretches
        if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_pair(draw_sample(), draw_sample());
      end
      no_idle = 1'b0;
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
